[design/osd_glyph_overlay_nv12_assert.svh]
// ----------------------------------------------------------------------------
// osd_glyph_overlay_nv12 assertion macros
// Shorthand for clocked concurrent assertions used by the port checker.
// ----------------------------------------------------------------------------
`ifndef OSD_GLYPH_OVERLAY_NV12_ASSERT_SVH
`define OSD_GLYPH_OVERLAY_NV12_ASSERT_SVH

// Checked only while reset is released.
`define OSDGO_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define OSDGO_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[design/osdgo_pkg.sv]
// ----------------------------------------------------------------------------
// osdgo_pkg
// Shared types, codes and constants of the NV12 glyph overlay writer.
// ----------------------------------------------------------------------------
`default_nettype none

package osdgo_pkg;

    localparam int GLYPH_MAX_DEF  = 64;
    localparam int COORD_BITS_DEF = 12;

    localparam logic [1:0] OP_TEXT_START = 2'd0;
    localparam logic [1:0] OP_NEWLINE    = 2'd1;
    localparam logic [1:0] OP_GLYPH_ROW  = 2'd2;
    localparam logic [1:0] OP_UNUSED     = 2'd3;

    localparam logic [2:0] REG_ORIGIN_X     = 3'd0;
    localparam logic [2:0] REG_ORIGIN_Y     = 3'd1;
    localparam logic [2:0] REG_IMAGE_WIDTH  = 3'd2;
    localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd3;
    localparam logic [2:0] REG_LINE_LIMIT   = 3'd4;
    localparam logic [2:0] REG_COLOR_Y      = 3'd5;
    localparam logic [2:0] REG_COLOR_U      = 3'd6;
    localparam logic [2:0] REG_COLOR_V      = 3'd7;

    localparam int ADDR_W      = 5;
    localparam int IN_TDATA_W  = 88;
    localparam int OUT_TDATA_W = 176;
    localparam int MASK_W      = 64;

    localparam logic [MASK_W-1:0] EVEN_BITS = 64'h5555_5555_5555_5555;

    typedef struct packed {
        logic [11:0] origin_x;
        logic [11:0] origin_y;
        logic [12:0] image_width;
        logic [12:0] image_height;
        logic [7:0]  line_limit;
        logic [7:0]  color_y;
        logic [7:0]  color_u;
        logic [7:0]  color_v;
    } cfg_t;

    typedef struct packed {
        logic [1:0]        operation;
        logic [6:0]        glyph_width;
        logic [6:0]        glyph_height;
        logic [5:0]        row_index;
        logic [MASK_W-1:0] row_mask;
    } item_t;

    typedef struct packed {
        logic              write_enable;
        logic [11:0]       luma_row;
        logic [11:0]       luma_col;
        logic [MASK_W-1:0] luma_mask;
        logic [10:0]       chroma_row;
        logic [11:0]       chroma_col;
        logic [MASK_W-1:0] chroma_mask;
        logic              stopped;
    } result_t;

endpackage

`default_nettype wire

[design/osd_glyph_overlay_nv12.sv]
// ----------------------------------------------------------------------------
// osd_glyph_overlay_nv12
// On-screen text overlay writer: turns glyph rows into NV12 luma and chroma
// masked writes, with line wrapping, clipping and a line limit.
// Registers: an input beat is held in the input register, its result beat in
// the result register. Throughput: one beat per cycle unless the output stalls;
// the pen, line and stop state update on each step, between the two registers.
// Reset: rst_n clears both stages, the pen, line index and stop flag, and
// returns the registers to their documented reset values.
// ----------------------------------------------------------------------------
`default_nettype none

module osd_glyph_overlay_nv12 #(
    parameter int GLYPH_MAX  = osdgo_pkg::GLYPH_MAX_DEF,
    parameter int COORD_BITS = osdgo_pkg::COORD_BITS_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [osdgo_pkg::ADDR_W-1:0]        paddr,
    input  wire logic [31:0]                         pwdata,
    output logic [31:0]                              prdata,
    output logic                                     pready,
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    // glyph_width, glyph_height, row_index, row_mask, zero pad
    input  wire logic [osdgo_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // operation
    input  wire logic [1:0]                          s_axis_tuser,
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // luma_row, luma_col, luma_mask, chroma_row, chroma_col, chroma_mask, pad
    output logic [osdgo_pkg::OUT_TDATA_W-1:0]        m_axis_tdata,
    // write_enable, stopped
    output logic [1:0]                               m_axis_tuser
);
    import osdgo_pkg::*;

    cfg_t    cfg_reg, cfg_next;
    item_t   item_reg;
    result_t res_reg, res_comb;
    logic    in_valid_reg, out_valid_reg;
    logic    advance, s_fire, step, cfg_wr;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign advance = !out_valid_reg || m_axis_tready;
    assign step    = in_valid_reg && advance;
    assign s_axis_tready = !in_valid_reg || advance;
    assign s_fire  = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr)
        begin
            case (paddr[4:2])
                REG_ORIGIN_X:     cfg_next.origin_x     = pwdata[11:0];
                REG_ORIGIN_Y:     cfg_next.origin_y     = pwdata[11:0];
                REG_IMAGE_WIDTH:  cfg_next.image_width  = pwdata[12:0];
                REG_IMAGE_HEIGHT: cfg_next.image_height = pwdata[12:0];
                REG_LINE_LIMIT:   cfg_next.line_limit   = pwdata[7:0];
                REG_COLOR_Y:      cfg_next.color_y      = pwdata[7:0];
                REG_COLOR_U:      cfg_next.color_u      = pwdata[7:0];
                REG_COLOR_V:      cfg_next.color_v      = pwdata[7:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[4:2])
            REG_ORIGIN_X:     prdata = 32'(cfg_reg.origin_x);
            REG_ORIGIN_Y:     prdata = 32'(cfg_reg.origin_y);
            REG_IMAGE_WIDTH:  prdata = 32'(cfg_reg.image_width);
            REG_IMAGE_HEIGHT: prdata = 32'(cfg_reg.image_height);
            REG_LINE_LIMIT:   prdata = 32'(cfg_reg.line_limit);
            REG_COLOR_Y:      prdata = 32'(cfg_reg.color_y);
            REG_COLOR_U:      prdata = 32'(cfg_reg.color_u);
            REG_COLOR_V:      prdata = 32'(cfg_reg.color_v);
            default:          prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.origin_x     <= 12'd0;
            cfg_reg.origin_y     <= 12'd0;
            cfg_reg.image_width  <= 13'd1920;
            cfg_reg.image_height <= 13'd1080;
            cfg_reg.line_limit   <= 8'd0;
            cfg_reg.color_y      <= 8'd255;
            cfg_reg.color_u      <= 8'd128;
            cfg_reg.color_v      <= 8'd128;
            in_valid_reg         <= 1'b0;
            out_valid_reg        <= 1'b0;
        end
        else
        begin
            cfg_reg       <= cfg_next;
            in_valid_reg  <= s_fire || (in_valid_reg && !advance);
            out_valid_reg <= step || (out_valid_reg && !m_axis_tready);
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            item_reg.operation    <= s_axis_tuser;
            item_reg.glyph_width  <= s_axis_tdata[6:0];
            item_reg.glyph_height <= s_axis_tdata[13:7];
            item_reg.row_index    <= s_axis_tdata[19:14];
            item_reg.row_mask     <= s_axis_tdata[83:20];
        end
        if (step)
        begin
            res_reg <= res_comb;
        end
    end

    osdgo_engine #(
        .GLYPH_MAX  (GLYPH_MAX),
        .COORD_BITS (COORD_BITS)
    ) u_engine (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .cfg    (cfg_reg),
        .item   (item_reg),
        .result (res_comb)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = {res_reg.stopped, res_reg.write_enable};
    assign m_axis_tdata  = {1'b0, res_reg.chroma_mask, res_reg.chroma_col,
                            res_reg.chroma_row, res_reg.luma_mask,
                            res_reg.luma_col, res_reg.luma_row};

endmodule

`default_nettype wire

[design/osdgo_engine.sv]
// ----------------------------------------------------------------------------
// osdgo_engine
// Pen, line and stop state plus the per-row wrap, clip and mask logic.
// ----------------------------------------------------------------------------
`default_nettype none

module osdgo_engine #(
    parameter int GLYPH_MAX  = osdgo_pkg::GLYPH_MAX_DEF,
    parameter int COORD_BITS = osdgo_pkg::COORD_BITS_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              step,
    input  wire osdgo_pkg::cfg_t   cfg,
    input  wire osdgo_pkg::item_t  item,
    output osdgo_pkg::result_t     result
);
    import osdgo_pkg::*;

    localparam logic [15:0] COORD_KEEP = 16'((32'd1 << COORD_BITS) - 1);

    logic [15:0] pen_reg, pen_next;
    logic [7:0]  line_reg, line_next;
    logic        halted_reg, halted_next;

    logic [6:0]        gw_s, gh_s;
    logic [7:0]        adv;
    logic              is_glyph, wrap, stop, last, in_image;
    logic [7:0]        line_bump, line_eff;
    logic [15:0]       pen_eff;
    logic [14:0]       prod;
    logic [15:0]       row;
    logic [12:0]       room, draw_w;
    logic [16:0]       pen_adv;
    logic [MASK_W-1:0] keep, mask;
    logic [15:0]       row_c, col_c;

    always_comb
    begin
        gw_s = (item.glyph_width > 7'(GLYPH_MAX)) ? 7'(GLYPH_MAX) : item.glyph_width;
        gh_s = (item.glyph_height > 7'(GLYPH_MAX)) ? 7'(GLYPH_MAX) : item.glyph_height;
        if (gh_s == 7'd0)
        begin
            gh_s = 7'd1;
        end
        adv       = (8'(gw_s) + 8'd1) & ~8'd1;
        line_bump = (line_reg == 8'hFF) ? line_reg : line_reg + 8'd1;
        is_glyph  = (item.operation == OP_GLYPH_ROW) && !halted_reg
                    && ({1'b0, item.row_index} < gh_s);
        wrap      = (item.row_index == 6'd0)
                    && ((17'(pen_reg) + 17'(adv)) > 17'(cfg.image_width));
        stop      = wrap && (cfg.line_limit != 8'd0) && (line_bump >= cfg.line_limit);
        line_eff  = wrap ? line_bump : line_reg;
        pen_eff   = wrap ? 16'(cfg.origin_x) : pen_reg;
        prod      = 15'(line_eff) * 15'(gh_s);
        row       = 16'(cfg.origin_y) + 16'(prod) + 16'(item.row_index);
        in_image  = (pen_eff < 16'(cfg.image_width)) && (row < 16'(cfg.image_height));
        room      = cfg.image_width - pen_eff[12:0];
        draw_w    = (13'(gw_s) > room) ? room : 13'(gw_s);
        for (int j = 0; j < MASK_W; j++)
        begin
            keep[j] = (13'(j) < draw_w);
        end
        mask      = (is_glyph && !stop && in_image) ? (item.row_mask & keep) : '0;
        last      = ({1'b0, item.row_index} == (gh_s - 7'd1));
        pen_adv   = 17'(pen_eff) + 17'(adv);

        pen_next    = pen_reg;
        line_next   = line_reg;
        halted_next = halted_reg;
        case (item.operation)
            OP_TEXT_START:
            begin
                pen_next    = 16'(cfg.origin_x);
                line_next   = 8'd0;
                halted_next = 1'b0;
            end
            OP_NEWLINE:
            begin
                if (!halted_reg)
                begin
                    pen_next  = 16'(cfg.origin_x);
                    line_next = line_bump;
                end
            end
            OP_GLYPH_ROW:
            begin
                if (is_glyph)
                begin
                    line_next = line_eff;
                    if (stop)
                    begin
                        halted_next = 1'b1;
                    end
                    else
                    begin
                        pen_next = pen_eff;
                        if (last)
                        begin
                            pen_next = pen_adv[16] ? 16'hFFFF : pen_adv[15:0];
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase

        row_c  = row & COORD_KEEP;
        col_c  = pen_eff & COORD_KEEP;
        result = '0;
        if (mask != '0)
        begin
            result.write_enable = 1'b1;
            result.luma_row     = row_c[11:0];
            result.luma_col     = col_c[11:0];
            result.luma_mask    = mask;
            result.chroma_row   = row_c[11:1];
            result.chroma_col   = {col_c[11:1], 1'b0};
            result.chroma_mask  = mask & EVEN_BITS;
        end
        result.stopped = halted_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pen_reg    <= '0;
            line_reg   <= '0;
            halted_reg <= 1'b0;
        end
        else if (step)
        begin
            pen_reg    <= pen_next;
            line_reg   <= line_next;
            halted_reg <= halted_next;
        end
    end

endmodule

`default_nettype wire

[design/osdgo_checker.sv]
// ----------------------------------------------------------------------------
// osdgo_checker
// Port-level checks of the overlay writer's result stream, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none
`include "osd_glyph_overlay_nv12_assert.svh"

module osdgo_checker (
    input wire logic                                clk,
    input wire logic                                rst_n,
    input wire logic                                m_axis_tvalid,
    input wire logic                                m_axis_tready,
    input wire logic [osdgo_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    input wire logic [1:0]                          m_axis_tuser
);
    import osdgo_pkg::*;

    `OSDGO_ASSERT_ALWAYS(a_idle_in_reset, clk, !rst_n |-> !m_axis_tvalid, "result valid in reset")
    `OSDGO_ASSERT(a_hold_on_stall, clk, rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")
    `OSDGO_ASSERT(a_no_write_zero, clk, rst_n, m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == '0, "fields set without a write")
    `OSDGO_ASSERT(a_chroma_follows, clk, rst_n, m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[98:88] == m_axis_tdata[11:1] && m_axis_tdata[110:100] == m_axis_tdata[23:13] && !m_axis_tdata[99] && m_axis_tdata[174:111] == (m_axis_tdata[87:24] & EVEN_BITS), "chroma write does not follow luma write")
    `OSDGO_ASSERT(a_write_live, clk, rst_n, m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[87:24] != '0 && !m_axis_tuser[1], "write while stopped or with empty mask")

endmodule

bind osd_glyph_overlay_nv12 osdgo_checker u_osdgo_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
